[rtl/rmedf_pkg.sv]
`default_nettype none

package rmedf_pkg;

  // table and field sizes
  localparam int NUM_TASKS = 8;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = 32;
  localparam int PAR_W     = 16;
  localparam int MASK_W    = 8;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // priority policy codes
  localparam logic POL_RATE = 1'b0;
  localparam logic POL_EDF  = 1'b1;

  // one task table entry
  typedef struct packed {
    logic                 valid;
    logic [PAR_W-1:0]     period;
    logic [PAR_W-1:0]     burst;
    logic [PAR_W-1:0]     rel_dl;
    logic [TIME_BITS-1:0] next_arr;
    logic [TIME_BITS-1:0] abs_dl;
    logic [PAR_W-1:0]     rem;
    logic                 ready;
    logic [CNT_W-1:0]     miss_cnt;
    logic [CNT_W-1:0]     done_cnt;
  } task_entry_t;

  // outcome of evaluating one entry during a tick scan
  typedef struct packed {
    task_entry_t          entry;
    logic                 missed;
    logic                 cand;
    logic [TIME_BITS-1:0] key;
  } eval_res_t;

  // saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rmedf_task_file.sv]
`default_nettype none

module rmedf_task_file
  import rmedf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] addr,
  input  wire logic             we,
  input  wire task_entry_t      wdata,
  output task_entry_t           rdata
);

  task_entry_t regs_r [NUM_TASKS];

  // single shared address for read and write
  assign rdata = regs_r[addr];

  // control fields and counters cleared at reset, parameters and times keep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        regs_r[i].valid    <= 1'b0;
        regs_r[i].rem      <= '0;
        regs_r[i].ready    <= 1'b0;
        regs_r[i].miss_cnt <= '0;
        regs_r[i].done_cnt <= '0;
      end
    end else if (we) begin
      regs_r[addr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/rmedf_task_eval.sv]
`default_nettype none

module rmedf_task_eval
  import rmedf_pkg::*;
(
  input  wire task_entry_t          entry_in,
  input  wire logic [TIME_BITS-1:0] tick_t,
  input  wire logic                 policy,
  input  wire logic                 best_valid,
  input  wire logic [TIME_BITS-1:0] best_key,
  output eval_res_t                 res
);

  task_entry_t e;
  logic        arrive;
  logic        miss;

  // release, then deadline check, then priority compare against best so far
  always_comb begin
    e      = entry_in;
    arrive = entry_in.valid && (entry_in.next_arr == tick_t);
    if (arrive) begin
      e.rem      = entry_in.burst;
      e.abs_dl   = tick_t + TIME_BITS'(entry_in.rel_dl);
      e.next_arr = entry_in.next_arr + TIME_BITS'(entry_in.period);
      e.ready    = (entry_in.burst != '0);
    end
    miss = e.ready && (e.rem != '0) && (e.abs_dl == tick_t);
    if (miss) begin
      e.miss_cnt = sat_inc(e.miss_cnt);
      e.rem      = '0;
      e.ready    = 1'b0;
    end
    res.entry  = e;
    res.missed = miss;
    res.key    = (policy == POL_EDF) ? e.abs_dl : TIME_BITS'(e.period);
    res.cand   = e.ready && (!best_valid || (res.key < best_key));
  end

endmodule

`default_nettype wire

[rtl/rm_edf_tick_scheduler.sv]
`default_nettype none

// Periodic task scheduler, rate monotonic or earliest deadline first.
// Input channel in_*: one beat is a command (load entry, tick, read counters)
// with its fields; in_stall is high while a command is being worked on.
// Output channel out_*: exactly one result beat per command, held in an
// output register until taken; out_stall from the receiver holds it.
// cfg_wr_en/cfg_wr_data write the policy bit (0 rate monotonic, 1 EDF); the user
// must write it only while the block is idle, the block itself does not enforce it.
// Sequence: a load or read passes through its own state and a push state
// before out_valid; a tick scans one table entry per cycle through the
// shared evaluate/compare unit, runs the winner (skipped when no task is
// ready) and then hands the result over. The next command can be accepted
// once the previous result sits in the output register; if that register is
// still stalled, the finished result waits and the block stays busy.
// Reset (rst_n low, synchronous) clears valid, ready, remaining work and
// all counters, sets policy to rate monotonic and empties the output.

module rm_edf_tick_scheduler
  import rmedf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [2:0]  in_task_index,
  input  wire logic [15:0] in_period,
  input  wire logic [15:0] in_burst,
  input  wire logic [15:0] in_rel_deadline,
  input  wire logic [31:0] in_first_arrival,
  input  wire logic [31:0] in_tick_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ran_valid,
  output logic [2:0]       out_ran_task,
  output logic             out_ran_completed,
  output logic [7:0]       out_missed_mask,
  output logic [31:0]      out_miss_total,
  output logic [31:0]      out_done_total
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_READ = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_RUN  = 6'b010000,
    ST_PUSH = 6'b100000
  } state_t;

  typedef struct packed {
    logic              ran_valid;
    logic [2:0]        ran_task;
    logic              ran_completed;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  done_total;
  } result_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 policy_r, policy_nxt;
  logic [PAR_W-1:0]     per_r, per_nxt;
  logic [PAR_W-1:0]     bur_r, bur_nxt;
  logic [PAR_W-1:0]     rel_r, rel_nxt;
  logic [TIME_BITS-1:0] first_r, first_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic                 best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_key_r, best_key_nxt;
  result_t              res_r, res_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 file_we;
  task_entry_t          file_wdata;
  task_entry_t          file_rdata;
  eval_res_t            ev;
  logic                 in_acc;
  logic                 idx_ok;
  logic                 out_free;

  rmedf_task_file u_file (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (addr_r),
    .we    (file_we),
    .wdata (file_wdata),
    .rdata (file_rdata)
  );

  rmedf_task_eval u_eval (
    .entry_in   (file_rdata),
    .tick_t     (t_r),
    .policy     (policy_r),
    .best_valid (best_valid_r),
    .best_key   (best_key_r),
    .res        (ev)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = (32'(in_task_index) < NUM_TASKS);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    policy_nxt     = cfg_wr_en ? cfg_wr_data : policy_r;
    per_nxt        = per_r;
    bur_nxt        = bur_r;
    rel_nxt        = rel_r;
    first_nxt      = first_r;
    t_nxt          = t_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    file_we        = 1'b0;
    file_wdata     = file_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt        = '0;
          addr_nxt       = IDX_W'(in_task_index);
          per_nxt        = in_period;
          bur_nxt        = in_burst;
          rel_nxt        = in_rel_deadline;
          first_nxt      = TIME_BITS'(in_first_arrival);
          t_nxt          = TIME_BITS'(in_tick_time);
          best_valid_nxt = 1'b0;
          case (in_cmd)
            CMD_LOAD: state_nxt = idx_ok ? ST_LOAD : ST_PUSH;
            CMD_READ: state_nxt = idx_ok ? ST_READ : ST_PUSH;
            CMD_TICK: begin
              addr_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_PUSH;
          endcase
        end
      end

      // rewrite parameters, keep counters and deadline
      ST_LOAD: begin
        file_we             = 1'b1;
        file_wdata.valid    = 1'b1;
        file_wdata.period   = per_r;
        file_wdata.burst    = bur_r;
        file_wdata.rel_dl   = rel_r;
        file_wdata.next_arr = first_r;
        file_wdata.rem      = '0;
        file_wdata.ready    = 1'b0;
        state_nxt           = ST_PUSH;
      end

      ST_READ: begin
        res_nxt.miss_total = file_rdata.miss_cnt;
        res_nxt.done_total = file_rdata.done_cnt;
        state_nxt          = ST_PUSH;
      end

      // one entry per cycle: release, miss, priority compare
      ST_SCAN: begin
        file_we    = 1'b1;
        file_wdata = ev.entry;
        if (ev.missed && (32'(addr_r) < MASK_W)) begin
          res_nxt.mask[3'(addr_r)] = 1'b1;
        end
        if (ev.cand) begin
          best_valid_nxt = 1'b1;
          best_idx_nxt   = addr_r;
          best_key_nxt   = ev.key;
        end
        if (addr_r == IDX_W'(NUM_TASKS - 1)) begin
          if (ev.cand) begin
            addr_nxt  = addr_r;
            state_nxt = ST_RUN;
          end else if (best_valid_r) begin
            addr_nxt  = best_idx_r;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_PUSH;
          end
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end

      // winner runs one unit
      ST_RUN: begin
        file_we           = 1'b1;
        res_nxt.ran_valid = 1'b1;
        res_nxt.ran_task  = 3'(addr_r);
        if (file_rdata.rem != '0) begin
          file_wdata.rem = file_rdata.rem - PAR_W'(1);
        end
        if (file_wdata.rem == '0) begin
          file_wdata.done_cnt   = sat_inc(file_rdata.done_cnt);
          file_wdata.ready      = 1'b0;
          res_nxt.ran_completed = 1'b1;
        end
        state_nxt = ST_PUSH;
      end

      // hand result to the output register
      ST_PUSH: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POL_RATE;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      policy_r     <= policy_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    per_r      <= per_nxt;
    bur_r      <= bur_nxt;
    rel_r      <= rel_nxt;
    first_r    <= first_nxt;
    t_r        <= t_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ran_valid     = out_r.ran_valid;
  assign out_ran_task      = out_r.ran_task;
  assign out_ran_completed = out_r.ran_completed;
  assign out_missed_mask   = out_r.mask;
  assign out_miss_total    = out_r.miss_total;
  assign out_done_total    = out_r.done_total;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rmedf_pkg::*;

  // cmd code that the block treats as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = NUM_TASKS + 6;
  localparam int MAX_REPORTS  = 100;
  localparam int LIMIT_NS     = 3_000_000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  idx;
    logic [15:0] period;
    logic [15:0] burst;
    logic [15:0] rel_dl;
    logic [31:0] first_arr;
    logic [31:0] tick_at;
  } sched_cmd_t;

  typedef struct packed {
    logic        ran_valid;
    logic [2:0]  ran_task;
    logic        ran_completed;
    logic [7:0]  missed_mask;
    logic [31:0] miss_total;
    logic [31:0] done_total;
  } sched_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [2:0]  in_task_index;
  logic [15:0] in_period;
  logic [15:0] in_burst;
  logic [15:0] in_rel_deadline;
  logic [31:0] in_first_arrival;
  logic [31:0] in_tick_time;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ran_valid;
  logic [2:0]  out_ran_task;
  logic        out_ran_completed;
  logic [7:0]  out_missed_mask;
  logic [31:0] out_miss_total;
  logic [31:0] out_done_total;

  rm_edf_tick_scheduler u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_index     (in_task_index),
    .in_period         (in_period),
    .in_burst          (in_burst),
    .in_rel_deadline   (in_rel_deadline),
    .in_first_arrival  (in_first_arrival),
    .in_tick_time      (in_tick_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ran_valid     (out_ran_valid),
    .out_ran_task      (out_ran_task),
    .out_ran_completed (out_ran_completed),
    .out_missed_mask   (out_missed_mask),
    .out_miss_total    (out_miss_total),
    .out_done_total    (out_done_total)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // scheduler model state
  logic              sched_policy;
  logic              tk_valid  [NUM_TASKS];
  logic [15:0]       tk_period [NUM_TASKS];
  logic [15:0]       tk_burst  [NUM_TASKS];
  logic [15:0]       tk_rel_dl [NUM_TASKS];
  logic [31:0]       tk_next   [NUM_TASKS];
  logic [31:0]       tk_abs_dl [NUM_TASKS];
  logic [15:0]       tk_left   [NUM_TASKS];
  logic              tk_ready  [NUM_TASKS];
  logic [31:0]       tk_misses [NUM_TASKS];
  logic [31:0]       tk_dones  [NUM_TASKS];

  sched_res_t sched_expected_q[$];

  int idle_pct;
  int stall_pct;
  logic rx_hold = 1'b0;
  event hold_ev;

  int n_sent, n_loads, n_ticks, n_reads, n_other;
  int n_checked, n_err, n_ran, n_misses, n_stalled_in;

  // clear model state as the block does on reset
  function automatic void sched_reset();
    sched_policy = POL_RATE;
    for (int i = 0; i < NUM_TASKS; i++) begin
      tk_valid[i]  = 1'b0;
      tk_period[i] = '0;
      tk_burst[i]  = '0;
      tk_rel_dl[i] = '0;
      tk_next[i]   = '0;
      tk_abs_dl[i] = '0;
      tk_left[i]   = '0;
      tk_ready[i]  = 1'b0;
      tk_misses[i] = '0;
      tk_dones[i]  = '0;
    end
  endfunction

  // candidate c (higher index) takes priority over current pick b
  function automatic logic outranks(int c, int b);
    if (sched_policy == POL_EDF) return tk_abs_dl[c] < tk_abs_dl[b];
    return tk_period[c] < tk_period[b];
  endfunction

  // apply one command to the model and return the beat it produces
  function automatic sched_res_t sched_apply(sched_cmd_t c);
    sched_res_t r;
    int best;
    r = '0;
    best = -1;
    case (c.cmd)
      CMD_LOAD: begin
        tk_valid[c.idx]  = 1'b1;
        tk_period[c.idx] = c.period;
        tk_burst[c.idx]  = c.burst;
        tk_rel_dl[c.idx] = c.rel_dl;
        tk_next[c.idx]   = c.first_arr;
        tk_left[c.idx]   = '0;
        tk_ready[c.idx]  = 1'b0;
      end
      CMD_TICK: begin
        // job releases
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (tk_valid[i] && tk_next[i] == c.tick_at) begin
            tk_left[i]   = tk_burst[i];
            tk_abs_dl[i] = c.tick_at + 32'(tk_rel_dl[i]);
            tk_next[i]   = tk_next[i] + 32'(tk_period[i]);
            tk_ready[i]  = (tk_burst[i] != 0);
          end
        end
        // deadline misses
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (tk_ready[i] && tk_left[i] != 0 && tk_abs_dl[i] == c.tick_at) begin
            if (tk_misses[i] != '1) tk_misses[i]++;
            tk_left[i]        = '0;
            tk_ready[i]       = 1'b0;
            r.missed_mask[i]  = 1'b1;
          end
        end
        // pick the winner, lower index wins ties
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (tk_ready[i] && (best < 0 || outranks(i, best))) best = i;
        end
        // run one unit
        if (best >= 0) begin
          r.ran_valid = 1'b1;
          r.ran_task  = 3'(best);
          if (tk_left[best] != 0) tk_left[best]--;
          if (tk_left[best] == 0) begin
            if (tk_dones[best] != '1) tk_dones[best]++;
            tk_ready[best]  = 1'b0;
            r.ran_completed = 1'b1;
          end
        end
      end
      CMD_READ: begin
        r.miss_total = tk_misses[c.idx];
        r.done_total = tk_dones[c.idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    c.cmd       = 2'($urandom_range(3));
    c.idx       = 3'($urandom_range(7));
    c.period    = 16'($urandom);
    c.burst     = 16'($urandom);
    c.rel_dl    = 16'($urandom);
    c.first_arr = $urandom;
    c.tick_at   = $urandom;
    return c;
  endfunction

  function automatic sched_cmd_t mk_cmd(logic [1:0] cmd, logic [2:0] idx, logic [15:0] period,
                                        logic [15:0] burst, logic [15:0] rel_dl,
                                        logic [31:0] first_arr, logic [31:0] tick_at);
    sched_cmd_t c;
    c.cmd       = cmd;
    c.idx       = idx;
    c.period    = period;
    c.burst     = burst;
    c.rel_dl    = rel_dl;
    c.first_arr = first_arr;
    c.tick_at   = tick_at;
    return c;
  endfunction

  // send one command beat, then record what it must produce
  task automatic send_cmd(sched_cmd_t c);
    sched_res_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= c.cmd;
    in_task_index    <= c.idx;
    in_period        <= c.period;
    in_burst         <= c.burst;
    in_rel_deadline  <= c.rel_dl;
    in_first_arrival <= c.first_arr;
    in_tick_time     <= c.tick_at;
    @(posedge clk);
    while (in_stall) begin
      n_stalled_in++;
      @(posedge clk);
    end
    r = sched_apply(c);
    sched_expected_q.push_back(r);
    n_sent++;
    case (c.cmd)
      CMD_LOAD: n_loads++;
      CMD_TICK: begin
        n_ticks++;
        if (r.ran_valid) n_ran++;
        n_misses += $countones(r.missed_mask);
      end
      CMD_READ: n_reads++;
      default:  n_other++;
    endcase
  endtask

  // stop sending and let every pending result come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sched_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(logic pol);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pol;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sched_policy = pol;
  endtask

  // load a task set around a random base time, then walk time forward
  task automatic run_task_set(int tick_goal);
    logic [31:0] base;
    logic [31:0] now;
    sched_cmd_t  c;
    int k;
    int r;
    base = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(40)) : $urandom;
    for (int i = 0; i < NUM_TASKS; i++) begin
      c = rand_cmd();
      c.cmd = CMD_LOAD;
      c.idx = 3'(i);
      if ($urandom_range(4) == 0) begin
        // dormant entry, far from this time window
        c.first_arr = base + 32'h4000_0000 + 32'($urandom_range(4096));
      end else begin
        c.period    = 16'($urandom_range(2, 24));
        c.burst     = 16'($urandom_range(1, ($urandom_range(3) == 0) ? 10 : 3));
        c.rel_dl    = 16'($urandom_range(1, c.period + 4));
        c.first_arr = base + 32'($urandom_range(0, c.period));
        if ($urandom_range(19) == 0) c.period = '0;
        if ($urandom_range(19) == 0) c.burst  = '0;
        if ($urandom_range(19) == 0) c.rel_dl = '0;
      end
      send_cmd(c);
    end
    now = base;
    k = 0;
    while (k < tick_goal) begin
      c = rand_cmd();
      r = $urandom_range(99);
      if (r < 6) begin
        c.cmd = CMD_READ;
      end else if (r < 8) begin
        // reload one entry mid-run
        c.cmd       = CMD_LOAD;
        c.period    = 16'($urandom_range(1, 20));
        c.burst     = 16'($urandom_range(1, 5));
        c.rel_dl    = 16'($urandom_range(1, 24));
        c.first_arr = now + 32'($urandom_range(0, 4));
      end else if (r < 10) begin
        // noise: unused code, stray tick time or garbage load
        case ($urandom_range(2))
          0:       c.cmd = CMD_UNUSED;
          1:       c.cmd = CMD_TICK;
          default: c.cmd = CMD_LOAD;
        endcase
      end else begin
        c.cmd = CMD_TICK;
        if (r < 12) now++;  // skipped tick, arrivals on it are lost
        c.tick_at = now;
        now++;
        k++;
      end
      send_cmd(c);
    end
  endtask

  // edges of the fields, wrap, zero burst/period/deadline, reload, unused code
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_cmd(mk_cmd(CMD_READ,   3'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0));
    send_cmd(mk_cmd(CMD_UNUSED, 3'd7, '1, '1, '1, '1, '1));
    send_cmd(mk_cmd(CMD_LOAD, 3'd0, 16'd4,      16'd2,      16'd3,      32'hFFFF_FFFE, '0));
    send_cmd(mk_cmd(CMD_LOAD, 3'd7, 16'd0,      16'd1,      16'hFFFF,   32'hFFFF_FFFF, '0));
    send_cmd(mk_cmd(CMD_LOAD, 3'd3, 16'hFFFF,   16'd0,      16'd1,      32'hFFFF_FFFE, '0));
    send_cmd(mk_cmd(CMD_LOAD, 3'd5, 16'd1,      16'hFFFF,   16'd2,      32'hFFFF_FFFF, '0));
    send_cmd(mk_cmd(CMD_LOAD, 3'd6, 16'd3,      16'd1,      16'd0,      32'd0,         '0));
    for (int i = 0; i < 6; i++)
      send_cmd(mk_cmd(CMD_TICK, 3'd0, '0, '0, '0, '0, 32'hFFFF_FFFE + 32'(i)));
    // reload a task that is still ready
    send_cmd(mk_cmd(CMD_LOAD, 3'd5, 16'hFFFF, 16'd1, 16'd1, 32'd5, '0));
    for (int i = 4; i < 7; i++)
      send_cmd(mk_cmd(CMD_TICK, 3'd0, '0, '0, '0, '0, 32'(i)));
    send_cmd(mk_cmd(CMD_READ, 3'd0, '0, '0, '0, '0, '0));
    send_cmd(mk_cmd(CMD_READ, 3'd5, '0, '0, '0, '0, '0));
    send_cmd(mk_cmd(CMD_READ, 3'd6, '0, '0, '0, '0, '0));
    send_cmd(mk_cmd(CMD_READ, 3'd7, '0, '0, '0, '0, '0));
  endtask

  // random task sets under both policies and four idle/stall mixes
  task automatic test_random_phases();
    int phase_idle  [4] = '{0, 76, 0, 38};
    int phase_stall [4] = '{0, 0, 76, 38};
    int goal;
    for (int p = 0; p < 4; p++) begin
      write_policy((p % 2 == 0) ? POL_EDF : POL_RATE);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      goal = n_sent + 400;
      while (n_sent < goal) run_task_set($urandom_range(20, 60));
    end
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_backpressure();
    write_policy(POL_EDF);
    idle_pct  = 0;
    stall_pct = 0;
    ->hold_ev;
    run_task_set(30);
  endtask

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
    end
  end

  // long hold-off, counted here in cycles
  initial begin
    forever begin
      @(hold_ev);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (n_err < MAX_REPORTS) $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  // compare each result beat with the oldest outstanding one
  always @(posedge clk) begin : result_check
    sched_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sched_expected_q.size() == 0) begin
        $error("result beat with no command outstanding");
        n_err++;
      end else begin
        want = sched_expected_q.pop_front();
        check_field("ran_valid",     32'(want.ran_valid),     32'(out_ran_valid));
        check_field("ran_task",      32'(want.ran_task),      32'(out_ran_task));
        check_field("ran_completed", 32'(want.ran_completed), 32'(out_ran_completed));
        check_field("missed_mask",   32'(want.missed_mask),   32'(out_missed_mask));
        check_field("miss_total",    want.miss_total,         out_miss_total);
        check_field("done_total",    want.done_total,         out_done_total);
        n_checked++;
      end
    end
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = '0;
    in_task_index    = '0;
    in_period        = '0;
    in_burst         = '0;
    in_rel_deadline  = '0;
    in_first_arrival = '0;
    in_tick_time     = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    n_sent = 0; n_loads = 0; n_ticks = 0; n_reads = 0; n_other = 0;
    n_checked = 0; n_err = 0; n_ran = 0; n_misses = 0; n_stalled_in = 0;
    sched_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();

    $display("covered %0d commands: %0d loads, %0d ticks, %0d reads, %0d other",
             n_sent, n_loads, n_ticks, n_reads, n_other);
    $display("both policies, four idle mixes, one long hold-off (%0d input stall cycles)",
             n_stalled_in);
    $display("%0d beats checked, %0d runs, %0d misses, %0d mismatches",
             n_checked, n_ran, n_misses, n_err);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
